// File: hw/rtl/raysph_pkg.sv
// ----------------------------------------------------------------------------
// Ray and sphere intersection package
// Widths, register indexes and the data carried along the cell chains.
// ----------------------------------------------------------------------------
package raysph_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int REG_WIDTH       = 31;
    localparam int DIST_WIDTH      = 31;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int HALF_WIDTH  = PROD_WIDTH / 2;
    localparam int WIDE_WIDTH  = 2 * PROD_WIDTH;
    localparam int H_WIDTH     = PROD_WIDTH + 2;
    localparam int DISC_WIDTH  = WIDE_WIDTH + 2;
    localparam int ROOT_WIDTH  = DISC_WIDTH / 2;
    localparam int SQREM_WIDTH = ROOT_WIDTH + 2;
    localparam int NUM_WIDTH   = H_WIDTH + 1;
    localparam int DREM_WIDTH  = PROD_WIDTH + 1;
    localparam int DIVN_WIDTH  = NUM_WIDTH - 1 + FRAC_BITS;
    localparam int DHI_WIDTH   = DIVN_WIDTH - DIST_WIDTH;
    localparam int SQ_STAGES   = ROOT_WIDTH;
    localparam int DIV_STAGES  = DIST_WIDTH;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};
    localparam logic [REG_WIDTH-1:0] RADIUS_RESET = REG_WIDTH'(6553600);
    localparam logic [REG_WIDTH-1:0] MIN_DIST_RESET = REG_WIDTH'(66);

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPHERE_RADIUS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_DISTANCE  = 2'd1;

    typedef struct packed {
        logic                       valid;
        logic                       geom_ok;
        logic signed [H_WIDTH-1:0]  h;
        logic [PROD_WIDTH-1:0]      a;
    } t_sq_side;

    typedef struct packed {
        logic [DISC_WIDTH-1:0]  rad;
        logic [SQREM_WIDTH-1:0] rem;
        logic [ROOT_WIDTH-1:0]  root;
        t_sq_side               side;
    } t_sq_data;

    typedef struct packed {
        logic                   ok;
        logic                   big;
        logic [DREM_WIDTH-1:0]  rem;
        logic [DIST_WIDTH-1:0]  low;
        logic [DIST_WIDTH-1:0]  quo;
    } t_div_lane;

    typedef struct packed {
        logic                   valid;
        logic                   geom_ok;
        logic [PROD_WIDTH-1:0]  a;
        t_div_lane [1:0]        lane;
    } t_div_data;

endpackage

// File: hw/rtl/ray_sphere_intersection_unit.sv
// ----------------------------------------------------------------------------
// Ray and sphere intersection unit
// An accepted input beat reaches its output beat through six front stages, one
// square root cell per root bit, one divider setup stage, one divider cell per
// distance bit and the output register.
// Throughput is one ray per cycle; a stalled output holds the whole chain.
// Synchronous active-low reset empties the pipeline and restores the registers.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [raysph_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [raysph_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [raysph_pkg::COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [raysph_pkg::COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [raysph_pkg::COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [raysph_pkg::COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [raysph_pkg::COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [raysph_pkg::COORD_WIDTH-1:0] i_dir_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_hit,
    output logic [raysph_pkg::DIST_WIDTH-1:0]      o_distance,
    output logic                                   o_saturated
);

    localparam int PW = raysph_pkg::PROD_WIDTH;
    localparam int HW = raysph_pkg::HALF_WIDTH;
    localparam int WW = raysph_pkg::WIDE_WIDTH;

    logic [raysph_pkg::REG_WIDTH-1:0] r_radius;
    logic [raysph_pkg::REG_WIDTH-1:0] r_min_dist;
    logic w_en;
    logic [4:0] r_v;

    logic signed [raysph_pkg::COORD_WIDTH-1:0] w_o [3];
    logic signed [raysph_pkg::COORD_WIDTH-1:0] w_d [3];
    logic [PW-1:0] r_p_dd [3];
    logic signed [PW-1:0] r_p_od [3];
    logic [PW-1:0] r_p_oo [3];
    logic [PW-1:0] r_p_rr;

    logic [PW-1:0] r_a2;
    logic signed [raysph_pkg::H_WIDTH-1:0] r_h2;
    logic signed [raysph_pkg::H_WIDTH-1:0] r_c2;

    logic [PW-1:0] r_a3, r_habs3, r_cabs3;
    logic signed [raysph_pkg::H_WIDTH-1:0] r_h3;
    logic r_cneg3, r_azero3;

    logic [PW-1:0] r_a4;
    logic signed [raysph_pkg::H_WIDTH-1:0] r_h4;
    logic r_cneg4, r_azero4;
    logic [PW-1:0] r_hh_ll, r_hh_lh, r_hh_hh;
    logic [PW-1:0] r_ac_ll, r_ac_lh, r_ac_hl, r_ac_hh;

    logic [PW-1:0] r_a5;
    logic signed [raysph_pkg::H_WIDTH-1:0] r_h5;
    logic r_cneg5, r_azero5;
    logic [WW-1:0] r_hsq5, r_ac5;
    logic [WW-1:0] w_hsq, w_ac;

    logic signed [raysph_pkg::DISC_WIDTH-1:0] w_disc;
    raysph_pkg::t_sq_data r_sq0;
    raysph_pkg::t_sq_data w_sq [raysph_pkg::SQ_STAGES+1];

    raysph_pkg::t_div_data r_dv0, n_dv0;
    raysph_pkg::t_div_data w_dv [raysph_pkg::DIV_STAGES+1];
    logic signed [raysph_pkg::NUM_WIDTH-1:0] w_nh, w_s, w_num [2];
    logic [raysph_pkg::DIVN_WIDTH-1:0] w_full [2];
    logic [raysph_pkg::DHI_WIDTH-1:0] w_hi [2];

    logic [1:0] w_acc;
    logic n_hit, n_sat;
    logic [raysph_pkg::DIST_WIDTH-1:0] n_dist;
    raysph_pkg::t_div_data w_last;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= raysph_pkg::RADIUS_RESET;
            r_min_dist <= raysph_pkg::MIN_DIST_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                raysph_pkg::REG_SPHERE_RADIUS: begin
                    r_radius <= i_cfg_data[raysph_pkg::REG_WIDTH-1:0];
                end
                raysph_pkg::REG_MIN_DISTANCE: begin
                    r_min_dist <= i_cfg_data[raysph_pkg::REG_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], i_in_valid};
        end
    end

    assign w_o[0] = i_origin_x;
    assign w_o[1] = i_origin_y;
    assign w_o[2] = i_origin_z;
    assign w_d[0] = i_dir_x;
    assign w_d[1] = i_dir_y;
    assign w_d[2] = i_dir_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_p_dd[k] <= PW'(w_d[k] * w_d[k]);
                r_p_od[k] <= PW'(w_o[k] * w_d[k]);
                r_p_oo[k] <= PW'(w_o[k] * w_o[k]);
            end
            r_p_rr <= PW'(r_radius * r_radius);

            r_a2 <= r_p_dd[0] + r_p_dd[1] + r_p_dd[2];
            r_h2 <= raysph_pkg::H_WIDTH'(r_p_od[0]) + raysph_pkg::H_WIDTH'(r_p_od[1])
                  + raysph_pkg::H_WIDTH'(r_p_od[2]);
            r_c2 <= $signed(raysph_pkg::H_WIDTH'(r_p_oo[0]) + raysph_pkg::H_WIDTH'(r_p_oo[1])
                  + raysph_pkg::H_WIDTH'(r_p_oo[2]) - raysph_pkg::H_WIDTH'(r_p_rr));

            r_a3     <= r_a2;
            r_h3     <= r_h2;
            r_habs3  <= PW'(r_h2[raysph_pkg::H_WIDTH-1] ? -r_h2 : r_h2);
            r_cabs3  <= PW'(r_c2[raysph_pkg::H_WIDTH-1] ? -r_c2 : r_c2);
            r_cneg3  <= r_c2[raysph_pkg::H_WIDTH-1];
            r_azero3 <= (r_a2 == '0);

            r_a4     <= r_a3;
            r_h4     <= r_h3;
            r_cneg4  <= r_cneg3;
            r_azero4 <= r_azero3;
            r_hh_ll  <= r_habs3[HW-1:0] * r_habs3[HW-1:0];
            r_hh_lh  <= r_habs3[HW-1:0] * r_habs3[PW-1:HW];
            r_hh_hh  <= r_habs3[PW-1:HW] * r_habs3[PW-1:HW];
            r_ac_ll  <= r_a3[HW-1:0] * r_cabs3[HW-1:0];
            r_ac_lh  <= r_a3[HW-1:0] * r_cabs3[PW-1:HW];
            r_ac_hl  <= r_a3[PW-1:HW] * r_cabs3[HW-1:0];
            r_ac_hh  <= r_a3[PW-1:HW] * r_cabs3[PW-1:HW];

            r_a5     <= r_a4;
            r_h5     <= r_h4;
            r_cneg5  <= r_cneg4;
            r_azero5 <= r_azero4;
            r_hsq5   <= w_hsq;
            r_ac5    <= w_ac;
        end
    end

    assign w_hsq = {r_hh_hh, r_hh_ll} + (WW'(r_hh_lh) << (HW + 1));
    assign w_ac  = {r_ac_hh, r_ac_ll} + (WW'(r_ac_lh) << HW) + (WW'(r_ac_hl) << HW);
    assign w_disc = r_cneg5
        ? $signed(raysph_pkg::DISC_WIDTH'(r_hsq5) + raysph_pkg::DISC_WIDTH'(r_ac5))
        : $signed(raysph_pkg::DISC_WIDTH'(r_hsq5) - raysph_pkg::DISC_WIDTH'(r_ac5));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq0.side.valid <= 1'b0;
        end else if (w_en) begin
            r_sq0.side.valid   <= r_v[4];
            r_sq0.side.geom_ok <= !r_azero5 && !w_disc[raysph_pkg::DISC_WIDTH-1];
            r_sq0.side.h       <= r_h5;
            r_sq0.side.a       <= r_a5;
            r_sq0.rad          <= w_disc;
            r_sq0.rem          <= '0;
            r_sq0.root         <= '0;
        end
    end

    assign w_sq[0] = r_sq0;

    for (genvar g = 0; g < raysph_pkg::SQ_STAGES; g++) begin : g_sqrt
        raysph_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_data  (w_sq[g]),
            .o_data  (w_sq[g+1])
        );
    end

    always_comb begin
        w_nh = -$signed({w_sq[raysph_pkg::SQ_STAGES].side.h[raysph_pkg::H_WIDTH-1],
                         w_sq[raysph_pkg::SQ_STAGES].side.h});
        w_s  = $signed({2'b00, w_sq[raysph_pkg::SQ_STAGES].root});
        w_num[0] = w_nh - w_s;
        w_num[1] = w_nh + w_s;
        n_dv0.valid   = w_sq[raysph_pkg::SQ_STAGES].side.valid;
        n_dv0.geom_ok = w_sq[raysph_pkg::SQ_STAGES].side.geom_ok;
        n_dv0.a       = w_sq[raysph_pkg::SQ_STAGES].side.a;
        for (int k = 0; k < 2; k++) begin
            w_full[k] = {w_num[k][raysph_pkg::NUM_WIDTH-2:0],
                         {raysph_pkg::FRAC_BITS{1'b0}}};
            w_hi[k]   = w_full[k][raysph_pkg::DIVN_WIDTH-1:raysph_pkg::DIST_WIDTH];
            n_dv0.lane[k].ok  = !w_num[k][raysph_pkg::NUM_WIDTH-1] && (w_num[k] != '0);
            n_dv0.lane[k].big = raysph_pkg::DREM_WIDTH'(w_hi[k])
                              >= {1'b0, w_sq[raysph_pkg::SQ_STAGES].side.a};
            n_dv0.lane[k].rem = raysph_pkg::DREM_WIDTH'(w_hi[k]);
            n_dv0.lane[k].low = w_full[k][raysph_pkg::DIST_WIDTH-1:0];
            n_dv0.lane[k].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0.valid <= 1'b0;
        end else if (w_en) begin
            r_dv0 <= n_dv0;
        end
    end

    assign w_dv[0] = r_dv0;

    for (genvar g = 0; g < raysph_pkg::DIV_STAGES; g++) begin : g_div
        raysph_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_data  (w_dv[g]),
            .o_data  (w_dv[g+1])
        );
    end

    assign w_last = w_dv[raysph_pkg::DIV_STAGES];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_acc[k] = w_last.lane[k].ok
                     && (w_last.lane[k].big || (w_last.lane[k].quo > r_min_dist));
        end
        n_hit  = w_last.geom_ok && (w_acc[0] || w_acc[1]);
        n_sat  = 1'b0;
        n_dist = '0;
        if (n_hit) begin
            if (w_acc[0]) begin
                n_sat  = w_last.lane[0].big;
                n_dist = w_last.lane[0].big ? raysph_pkg::DIST_MAX : w_last.lane[0].quo;
            end else begin
                n_sat  = w_last.lane[1].big;
                n_dist = w_last.lane[1].big ? raysph_pkg::DIST_MAX : w_last.lane[1].quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit       <= n_hit;
            o_distance  <= n_dist;
            o_saturated <= n_sat;
        end
    end

`ifndef NO_ASSERTIONS
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_distance == '0 && !o_saturated))
        else $error("miss carries a distance or saturation flag");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_hit && o_distance == raysph_pkg::DIST_MAX))
        else $error("saturated result without full-scale hit");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v[0])
        else $error("accepted beat did not enter the pipeline");
`endif

endmodule

// File: hw/rtl/raysph_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one bit of the root from the next two bits of the radicand.
// ----------------------------------------------------------------------------
module raysph_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  raysph_pkg::t_sq_data i_data,
    output raysph_pkg::t_sq_data o_data
);

    raysph_pkg::t_sq_data r_data;
    raysph_pkg::t_sq_data n_data;
    logic [raysph_pkg::SQREM_WIDTH-1:0] w_rem_sh;
    logic [raysph_pkg::SQREM_WIDTH-1:0] w_trial;
    logic w_ge;

    always_comb begin
        w_rem_sh = {i_data.rem[raysph_pkg::SQREM_WIDTH-3:0],
                    i_data.rad[raysph_pkg::DISC_WIDTH-1 -: 2]};
        w_trial  = {i_data.root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
        n_data      = i_data;
        n_data.rad  = {i_data.rad[raysph_pkg::DISC_WIDTH-3:0], 2'b00};
        n_data.rem  = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
        n_data.root = {i_data.root[raysph_pkg::ROOT_WIDTH-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.side.valid <= 1'b0;
        end else if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// File: hw/rtl/raysph_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// Produces one quotient bit for each of the two root lanes.
// ----------------------------------------------------------------------------
module raysph_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  raysph_pkg::t_div_data i_data,
    output raysph_pkg::t_div_data o_data
);

    raysph_pkg::t_div_data r_data;
    raysph_pkg::t_div_data n_data;
    logic [raysph_pkg::DREM_WIDTH-1:0] w_rem_sh [2];
    logic [raysph_pkg::DREM_WIDTH-1:0] w_den;
    logic w_ge [2];

    always_comb begin
        n_data = i_data;
        w_den  = {1'b0, i_data.a};
        for (int k = 0; k < 2; k++) begin
            w_rem_sh[k] = {i_data.lane[k].rem[raysph_pkg::DREM_WIDTH-2:0],
                           i_data.lane[k].low[raysph_pkg::DIST_WIDTH-1]};
            w_ge[k] = (w_rem_sh[k] >= w_den);
            n_data.lane[k].rem = w_ge[k] ? (w_rem_sh[k] - w_den) : w_rem_sh[k];
            n_data.lane[k].low = {i_data.lane[k].low[raysph_pkg::DIST_WIDTH-2:0], 1'b0};
            n_data.lane[k].quo = {i_data.lane[k].quo[raysph_pkg::DIST_WIDTH-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule
